// ===== hdl/mandelbrot_escape_time_defines.svh =====
// assertion macros for the mandelbrot escape-time block
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

`ifndef ASSERT_OFF
`define MBROT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbrot check failed");
`define MBROT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbrot check failed");
`else
`define MBROT_ASSERT_IMP(name, ante, cons)
`define MBROT_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== hdl/mbrot_pkg.sv =====
// types, constants and helpers for the mandelbrot escape-time block
package mbrot_pkg;

  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int LIMIT_W   = 16;
  localparam int CNT_W     = LIMIT_W + 1;
  localparam int MAG_W     = 40;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAILOUT = 1'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 16'd2000;
  localparam logic               BAILOUT_RESET = 1'b1;

  // escape thresholds as integers, scaled by the fraction bits in use
  localparam logic [7:0] BAIL_BASE  = 8'd4;
  localparam logic [7:0] BAIL_EXTRA = 8'd124;

  typedef struct packed {
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] iter_count;
    logic             inside_set;
    logic [MAG_W-1:0] final_magnitude_sq;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_MXY,
    ST_CHK
  } state_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - PROD_W'(1);
    if (v > hi) begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/mandelbrot_escape_time.sv =====
// mandelbrot escape-time iteration for one point, top level
//
// Usage: drive in_data with a point c (two's complement, FRAC_BITS fraction
// bits) and raise start while busy is low; the item is taken at that edge.
// The block iterates z = z*z + c starting from z = c and returns one result
// on out_data, marked by a one-cycle out_valid strobe: the iteration count,
// the in-set flag and the final |z|^2 (saturated to 40 bits).
// Each iteration uses the single shared 32x32 multiplier in turn for
// x*x, y*y and x*y, then does the escape check and z update in ST_CHK.
// The strobe is registered when ST_CHK stops the loop; with the default
// limit of 2000, iter_count reaches at most 2001 (one past the limit).
// busy drops in the strobe cycle, so the next item may start right then.
// The receiver cannot stall: out_data is valid only during the strobe.
// cfg_we writes iteration_limit (index 0) or large_bailout (index 1);
// writes are meant for idle periods only.
// Reset (rst_n low, synchronous) returns to idle, drops the strobe and
// sets iteration_limit to 2000 and large_bailout to 1.
`include "mandelbrot_escape_time_defines.svh"

module mandelbrot_escape_time #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  mbrot_pkg::in_item_t                   in_data,
  output logic                                  out_valid,
  output mbrot_pkg::out_item_t                  out_data,
  input  logic                                  cfg_we,
  input  logic [mbrot_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbrot_pkg::CFG_W-1:0]           cfg_data
);
  import mbrot_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               bail_r, bail_nxt;

  logic signed [COORD_W-1:0] x_r, x_nxt;
  logic signed [COORD_W-1:0] y_r, y_nxt;
  logic signed [COORD_W-1:0] cr_r, cr_nxt;
  logic signed [COORD_W-1:0] ci_r, ci_nxt;
  logic signed [PROD_W-1:0]  xx_r, xx_nxt;
  logic signed [PROD_W-1:0]  yy_r, yy_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic signed [COORD_W-1:0] mul_a;
  logic signed [COORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [PROD_W-1:0]  mag_sum;
  logic [PROD_W-1:0]  mag_full;
  logic [PROD_W-1:0]  thresh;
  logic [MAG_W-1:0]   mag_sat;
  logic [CNT_W-1:0]   limit_ext;
  logic               stop;
  logic signed [PROD_W-1:0] nx_wide;
  logic signed [PROD_W-1:0] ny_wide;

  mbrot_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // operand select: x*x, then y*y, then x*y
  assign mul_a = (state_r == ST_SQY) ? y_r : x_r;
  assign mul_b = (state_r == ST_SQX) ? x_r : y_r;

  assign mag_sum   = $unsigned(xx_r) + $unsigned(yy_r);
  assign mag_full  = mag_sum >> FRAC_BITS;
  assign thresh    = PROD_W'(bail_r ? (BAIL_BASE + BAIL_EXTRA) : BAIL_BASE) << FRAC_BITS;
  assign mag_sat   = (|mag_full[PROD_W-1:MAG_W]) ? {MAG_W{1'b1}} : mag_full[MAG_W-1:0];
  assign limit_ext = {1'b0, limit_r};
  assign stop      = (count_r > limit_ext) || (mag_full > thresh);

  // prod holds x*y during the check cycle
  assign nx_wide = (xx_r >>> FRAC_BITS) - (yy_r >>> FRAC_BITS) + PROD_W'(cr_r);
  assign ny_wide = (prod >>> (FRAC_BITS - 1)) + PROD_W'(ci_r);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    limit_nxt     = limit_r;
    bail_nxt      = bail_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    xx_nxt        = xx_r;
    yy_nxt        = yy_r;
    count_nxt     = count_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_LIMIT:   limit_nxt = cfg_data[LIMIT_W-1:0];
        CFG_IDX_BAILOUT: bail_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt     = in_data.c_real;
          y_nxt     = in_data.c_imag;
          cr_nxt    = in_data.c_real;
          ci_nxt    = in_data.c_imag;
          count_nxt = '0;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        xx_nxt    = prod;
        state_nxt = ST_MXY;
      end
      ST_MXY: begin
        yy_nxt    = prod;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (stop) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.iter_count         = count_r;
          out_data_nxt.inside_set         = (count_r == limit_ext + CNT_W'(1));
          out_data_nxt.final_magnitude_sq = mag_sat;
          state_nxt                       = ST_IDLE;
        end else begin
          x_nxt     = sat_coord(nx_wide);
          y_nxt     = sat_coord(ny_wide);
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_SQX;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
      bail_r      <= BAILOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      limit_r     <= limit_nxt;
      bail_r      <= bail_nxt;
    end
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    cr_r       <= cr_nxt;
    ci_r       <= ci_nxt;
    xx_r       <= xx_nxt;
    yy_r       <= yy_nxt;
    count_r    <= count_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MBROT_ASSERT_NXT(a_start_enters_loop, start && !busy, state_r == ST_SQX)
  `MBROT_ASSERT_IMP(a_strobe_only_idle, out_valid_r, state_r == ST_IDLE)
  `MBROT_ASSERT_NXT(a_count_steps, (state_r == ST_CHK) && !stop, (state_r == ST_SQX) && (count_r == $past(count_r) + CNT_W'(1)))
  `MBROT_ASSERT_IMP(a_count_bound, out_valid_r, out_data_r.iter_count <= limit_ext + CNT_W'(1))

endmodule

// ===== hdl/mbrot_mul.sv =====
// shared signed multiplier with registered product
module mbrot_mul (
  input  logic                                     clk,
  input  logic signed [mbrot_pkg::COORD_W-1:0]     op_a,
  input  logic signed [mbrot_pkg::COORD_W-1:0]     op_b,
  output logic signed [mbrot_pkg::PROD_W-1:0]      prod_r
);
  import mbrot_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== tb/mandelbrot_escape_time_tb.sv =====
// self-checking testbench for the mandelbrot escape-time block
module mandelbrot_escape_time_tb;
  import mbrot_pkg::*;

  localparam int FRAC_BITS = 28;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int C_MAX = 32'sh7FFF_FFFF;
  localparam int C_MIN = 32'sh8000_0000;
  localparam int NEAR_MAX = 32'sh7E66_6666;  // about 7.9
  // window around the set: real -2.5 .. 1.0, imag -1.5 .. 1.5
  localparam int RE_LOW = -(ONE * 5 / 2);
  localparam int RE_SPAN = ONE * 7 / 2;
  localparam int IM_LOW = -(ONE * 3 / 2);
  localparam int IM_SPAN = ONE * 3;
  localparam longint unsigned MAG_MAX = (64'd1 << MAG_W) - 64'd1;
  localparam int WATCHDOG_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // shadow copy of the configuration registers
  logic [LIMIT_W-1:0] limit_q = LIMIT_RESET;
  logic bail_q = BAILOUT_RESET;

  out_item_t pending_results[$];
  out_item_t want;
  int error_count = 0;
  int quiet_cycles = 0;

  mandelbrot_escape_time #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned magnitude_sq(longint signed x, longint signed y);
    longint unsigned xx;
    longint unsigned yy;
    xx = x * x;
    yy = y * y;
    return (xx + yy) >> FRAC_BITS;
  endfunction

  function automatic longint signed clamp_coord(longint signed v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return v;
  endfunction

  // escape-time count, in-set flag and final |z|^2 for one point
  function automatic out_item_t escape_time(int re, int im, logic [LIMIT_W-1:0] limit,
                                            logic big);
    longint signed x;
    longint signed y;
    longint signed sq_x;
    longint signed sq_y;
    longint signed prod_xy;
    longint unsigned bound;
    longint unsigned mag;
    int n;
    out_item_t r;
    x = re;
    y = im;
    bound = big ? (BAIL_BASE + BAIL_EXTRA) : BAIL_BASE;
    bound = bound << FRAC_BITS;
    n = 0;
    while (n <= int'(limit) && magnitude_sq(x, y) <= bound) begin
      sq_x = (x * x) >>> FRAC_BITS;
      sq_y = (y * y) >>> FRAC_BITS;
      prod_xy = (x * y) >>> (FRAC_BITS - 1);
      x = clamp_coord(sq_x - sq_y + longint'(re));
      y = clamp_coord(prod_xy + longint'(im));
      n++;
    end
    mag = magnitude_sq(x, y);
    if (mag > MAG_MAX) mag = MAG_MAX;
    r.iter_count = n[CNT_W-1:0];
    r.inside_set = (n == int'(limit) + 1);
    r.final_magnitude_sq = mag[MAG_W-1:0];
    return r;
  endfunction

  // start stays high after acceptance so back-to-back items need no extra step
  task automatic send_point(int re, int im);
    in_item_t p;
    p.c_real = re;
    p.c_imag = im;
    start <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(escape_time(re, im, limit_q, bail_q));
  endtask

  task automatic drain_results;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // bailout value is written raw, the register keeps bit 0 only
  task automatic set_config(logic [CFG_W-1:0] lim, logic [CFG_W-1:0] bail_raw);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_LIMIT;
    cfg_data <= lim;
    @(posedge clk);
    cfg_index <= CFG_IDX_BAILOUT;
    cfg_data <= bail_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_q = lim[LIMIT_W-1:0];
    bail_q = bail_raw[0];
  endtask

  task automatic test_reset_defaults;
    send_point(0, 0);
    send_point(-ONE, 0);
    send_point(C_MIN, 0);
    send_point(C_MAX, C_MAX);
    send_point(ONE / 4, ONE / 2);
  endtask

  task automatic test_field_extremes;
    set_config(16'd16, 16'd0);
    send_point(C_MAX, C_MIN);
    send_point(C_MIN, C_MAX);
    send_point(0, C_MIN);
    send_point(C_MAX, 0);
    send_point(1, -1);
    send_point(-1, 1);
    send_point(C_MIN, C_MIN);
  endtask

  // z leaves the coordinate range but stays under the large bailout
  task automatic test_saturation;
    set_config(16'd24, 16'd1);
    send_point(NEAR_MAX, 0);
    send_point(0, NEAR_MAX);
    send_point(-NEAR_MAX, NEAR_MAX);
    send_point(3 * ONE, 3 * ONE);
  endtask

  // a point that escapes exactly on the last allowed iteration still counts as inside
  task automatic test_last_escape;
    out_item_t probe;
    int re;
    int im;
    logic found;
    for (int b = 0; b < 2; b++) begin
      found = 1'b0;
      repeat (4000) begin
        if (!found) begin
          re = int'($urandom_range(0, RE_SPAN)) + RE_LOW;
          im = int'($urandom_range(0, IM_SPAN)) + IM_LOW;
          probe = escape_time(re, im, 16'd300, b[0]);
          if (!probe.inside_set && probe.iter_count >= 3) found = 1'b1;
        end
      end
      if (found) begin
        set_config(CFG_W'(probe.iter_count - 1), CFG_W'(b));
        send_point(re, im);
        set_config(CFG_W'(probe.iter_count), CFG_W'(b));
        send_point(re, im);
      end
    end
  endtask

  task automatic test_limit_extremes;
    set_config(16'd0, 16'hFFFE);
    send_point(0, 0);
    send_point(ONE * 3 / 2, 0);
    send_point(C_MIN, C_MIN);
    set_config(16'hFFFF, 16'd1);
    send_point(0, 0);
    send_point(ONE * 3 / 2, 0);
    send_point(ONE / 2, ONE / 2);
  endtask

  task automatic test_random_points;
    int n_items;
    int sent;
    int burst;
    int gap;
    int re;
    int im;
    logic paused;
    logic [CFG_W-1:0] lim;
    for (int phase = 0; phase < 8; phase++) begin
      n_items = (phase == 4) ? 20 : 35;
      if (phase == 4) lim = CFG_W'($urandom_range(300, 800));
      else if (phase == 6) lim = CFG_W'($urandom_range(0, 3));
      else lim = CFG_W'($urandom_range(1, 64));
      set_config(lim, CFG_W'($urandom));
      sent = 0;
      paused = 1'b0;
      while (sent < n_items) begin
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst && sent < n_items; k++) begin
          // mostly points near the set, some anywhere in the full range
          if ($urandom_range(0, 99) < 15) begin
            re = $urandom;
            im = $urandom;
          end else begin
            re = int'($urandom_range(0, RE_SPAN)) + RE_LOW;
            im = int'($urandom_range(0, IM_SPAN)) + IM_LOW;
          end
          send_point(re, im);
          sent++;
        end
        // hold off once until everything in flight has come back
        if (phase == 3 && !paused && sent >= n_items / 2) begin
          paused = 1'b1;
          drain_results();
        end
        gap = (phase == 2 || phase == 5) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.iter_count !== want.iter_count) begin
          $display("%0t: iter_count expected %0d actual %0d", $time, want.iter_count,
                   out_data.iter_count);
          error_count++;
        end
        if (out_data.inside_set !== want.inside_set) begin
          $display("%0t: inside_set expected %0b actual %0b", $time, want.inside_set,
                   out_data.inside_set);
          error_count++;
        end
        if (out_data.final_magnitude_sq !== want.final_magnitude_sq) begin
          $display("%0t: final_magnitude_sq expected %h actual %h", $time,
                   want.final_magnitude_sq, out_data.final_magnitude_sq);
          error_count++;
        end
      end
    end
  end

  // ends a hung run: counts cycles with no item taken and no result
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_saturation();
    test_last_escape();
    test_limit_extremes();
    test_random_points();
    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
